// ===== design/abs_pkg.sv =====
package abs_pkg;

  localparam int QUEUE_DEPTH  = 1024;
  localparam int PTR_W        = $clog2(QUEUE_DEPTH);
  localparam int CNT_W        = $clog2(QUEUE_DEPTH + 1);
  localparam int PAYLOAD_BYTES = 20;
  localparam int SUM_W        = $clog2(PAYLOAD_BYTES * 255 + 1);
  localparam int CKS_W        = 16;

  typedef enum logic [1:0] {
    OP_MSG     = 2'd0,
    OP_PACKET  = 2'd1,
    OP_TIMEOUT = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    TMR_NONE  = 2'd0,
    TMR_START = 2'd1,
    TMR_STOP  = 2'd2
  } timer_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_WAIT = 1'b1
  } sender_state_t;

  // one queued message, with its byte sum kept alongside
  typedef struct packed {
    logic [63:0]      low;
    logic [63:0]      mid;
    logic [31:0]      high;
    logic [SUM_W-1:0] sum;
  } entry_t;

  // pairwise adder tree over the 20 payload bytes
  function automatic logic [SUM_W-1:0] payload_sum(input logic [63:0] lo,
                                                   input logic [63:0] mid,
                                                   input logic [31:0] hi);
    logic [SUM_W-1:0] t [PAYLOAD_BYTES];
    int               n;
    for (int i = 0; i < 8; i++) begin
      t[i]     = SUM_W'(lo[8*i +: 8]);
      t[8 + i] = SUM_W'(mid[8*i +: 8]);
    end
    for (int i = 0; i < 4; i++) begin
      t[16 + i] = SUM_W'(hi[8*i +: 8]);
    end
    n = PAYLOAD_BYTES;
    for (int lvl = 0; lvl < 5; lvl++) begin
      if (n > 1) begin
        for (int i = 0; i < n / 2; i++) begin
          t[i] = t[2*i] + t[2*i + 1];
        end
        if (n % 2 == 1) begin
          t[n / 2] = t[n - 1];
        end
        n = (n + 1) / 2;
      end
    end
    return t[0];
  endfunction

endpackage

// ===== design/alternating_bit_sender_unit.sv =====
// Alternating-bit protocol sender.
// Request channel (req_valid / req_stall): one event per request, opcode
// selects a message from above, an arriving packet or a timer expiry.
// Response channel (rsp_valid / rsp_stall): exactly one response per request,
// in order, carrying the packet to send (if any), the timer command and the
// drop flag for a message lost to a full queue.
// A request passes the input register, then the result register, on its way to
// a response. Throughput: one request per cycle while the receiver does not stall;
// all decisions on one event are made in the combinational logic between the
// registers, and the message queue memory keeps its head entry prefetched in a register.
// The queue holds QUEUE_DEPTH messages of 20 bytes each.
// Reset clears the sequence bit, the held packet, the queue pointers and
// both pipeline valids; queue memory contents are not cleared and need no
// sweep. When the receiver stalls, the response holds and the input register
// fills, after which req_stall rises until the response is taken.
module alternating_bit_sender_unit
  import abs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [1:0]  opcode,
  input  logic [63:0] payload_low,
  input  logic [63:0] payload_mid,
  input  logic [31:0] payload_high,
  input  logic        ack_number,
  input  logic        seq_number,
  input  logic [15:0] checksum_in,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic        send_valid,
  output logic        out_seq,
  output logic        out_ack,
  output logic [15:0] out_checksum,
  output logic [63:0] out_payload_low,
  output logic [63:0] out_payload_mid,
  output logic [31:0] out_payload_high,
  output logic [1:0]  timer_action,
  output logic        message_dropped
);

  // input register
  logic             s1_valid;
  opcode_t          s1_opcode;
  logic [63:0]      s1_low;
  logic [63:0]      s1_mid;
  logic [31:0]      s1_high;
  logic [SUM_W-1:0] s1_sum;
  logic             s1_ack;
  logic             s1_seq;
  logic [CKS_W-1:0] s1_cks;

  // sender state
  sender_state_t    state, state_next;
  logic             send_bit, send_bit_next;
  logic [PTR_W-1:0] head, head_next;
  logic [PTR_W-1:0] tail, tail_next;
  logic [CNT_W-1:0] count, count_next;
  logic [63:0]      held_low, held_low_next;
  logic [63:0]      held_mid, held_mid_next;
  logic [31:0]      held_high, held_high_next;
  logic [CKS_W-1:0] held_checksum, held_checksum_next;

  entry_t           queue_mem [QUEUE_DEPTH];
  entry_t           head_entry;
  entry_t           wr_entry;
  logic             q_we;

  logic             advance;
  logic             fire;
  logic             ack_ok;
  logic             queue_empty;
  logic             queue_full;
  logic [CKS_W-1:0] ack_check;

  logic             res_send;
  logic             res_seq;
  logic [CKS_W-1:0] res_checksum;
  logic [63:0]      res_low;
  logic [63:0]      res_mid;
  logic [31:0]      res_high;
  timer_t           res_timer;
  logic             res_dropped;

  assign advance   = !rsp_valid || !rsp_stall;
  assign req_stall = s1_valid && !advance;
  assign fire      = s1_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!req_stall) begin
      s1_valid <= req_valid;
    end
  end

  // byte sum is taken on the way into the input register
  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      s1_opcode <= opcode_t'(opcode);
      s1_low    <= payload_low;
      s1_mid    <= payload_mid;
      s1_high   <= payload_high;
      s1_sum    <= payload_sum(payload_low, payload_mid, payload_high);
      s1_ack    <= ack_number;
      s1_seq    <= seq_number;
      s1_cks    <= checksum_in;
    end
  end

  assign ack_check   = CKS_W'(s1_sum) + CKS_W'(s1_ack) + CKS_W'(s1_seq);
  assign queue_empty = (count == '0);
  assign queue_full  = (count == CNT_W'(QUEUE_DEPTH));
  assign ack_ok      = (state == ST_WAIT) && (s1_ack == send_bit) && (ack_check == s1_cks);

  always_comb begin
    state_next = state;
    if (fire) begin
      case (s1_opcode)
        OP_MSG: begin
          if (state == ST_IDLE) state_next = ST_WAIT;
        end
        OP_PACKET: begin
          if (ack_ok && queue_empty) state_next = ST_IDLE;
        end
        default: state_next = state;
      endcase
    end
  end

  always_comb begin
    send_bit_next      = send_bit;
    head_next          = head;
    tail_next          = tail;
    count_next         = count;
    held_low_next      = held_low;
    held_mid_next      = held_mid;
    held_high_next     = held_high;
    held_checksum_next = held_checksum;
    q_we               = 1'b0;
    wr_entry           = '{low: s1_low, mid: s1_mid, high: s1_high, sum: s1_sum};
    res_send           = 1'b0;
    res_seq            = 1'b0;
    res_timer          = TMR_NONE;
    res_dropped        = 1'b0;
    if (fire) begin
      case (s1_opcode)
        OP_MSG: begin
          if (state == ST_IDLE) begin
            held_low_next      = s1_low;
            held_mid_next      = s1_mid;
            held_high_next     = s1_high;
            held_checksum_next = CKS_W'(s1_sum) + CKS_W'(send_bit);
            res_send           = 1'b1;
            res_seq            = send_bit;
            res_timer          = TMR_START;
          end else if (queue_full) begin
            res_dropped = 1'b1;
          end else begin
            q_we       = 1'b1;
            tail_next  = (tail == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail + 1'b1;
            count_next = count + 1'b1;
          end
        end
        OP_PACKET: begin
          if (ack_ok) begin
            send_bit_next = !send_bit;
            if (!queue_empty) begin
              held_low_next      = head_entry.low;
              held_mid_next      = head_entry.mid;
              held_high_next     = head_entry.high;
              held_checksum_next = CKS_W'(head_entry.sum) + CKS_W'(!send_bit);
              head_next  = (head == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head + 1'b1;
              count_next = count - 1'b1;
              res_send   = 1'b1;
              res_seq    = !send_bit;
              res_timer  = TMR_START;
            end else begin
              res_timer = TMR_STOP;
            end
          end
        end
        OP_TIMEOUT: begin
          if (state == ST_WAIT) begin
            res_send  = 1'b1;
            res_seq   = send_bit;
            res_timer = TMR_START;
          end
        end
        default: res_send = 1'b0;
      endcase
    end
  end

  // the packet sent is always the one now held
  assign res_checksum = res_send ? held_checksum_next : '0;
  assign res_low      = res_send ? held_low_next : '0;
  assign res_mid      = res_send ? held_mid_next : '0;
  assign res_high     = res_send ? held_high_next : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      send_bit      <= 1'b0;
      head          <= '0;
      tail          <= '0;
      count         <= '0;
      held_low      <= '0;
      held_mid      <= '0;
      held_high     <= '0;
      held_checksum <= '0;
    end else begin
      state         <= state_next;
      send_bit      <= send_bit_next;
      head          <= head_next;
      tail          <= tail_next;
      count         <= count_next;
      held_low      <= held_low_next;
      held_mid      <= held_mid_next;
      held_high     <= held_high_next;
      held_checksum <= held_checksum_next;
    end
  end

  // queue memory, head entry prefetched with write bypass
  always_ff @(posedge clk) begin
    if (q_we) begin
      queue_mem[tail] <= wr_entry;
    end
    if (q_we && (tail == head_next)) begin
      head_entry <= wr_entry;
    end else begin
      head_entry <= queue_mem[head_next];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      send_valid       <= res_send;
      out_seq          <= res_seq;
      out_ack          <= 1'b0;
      out_checksum     <= res_checksum;
      out_payload_low  <= res_low;
      out_payload_mid  <= res_mid;
      out_payload_high <= res_high;
      timer_action     <= res_timer;
      message_dropped  <= res_dropped;
    end
  end

endmodule

// ===== design/abs_checker.sv =====
module abs_checker
  import abs_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        rsp_valid,
  input logic        rsp_stall,
  input logic        send_valid,
  input logic        out_seq,
  input logic        out_ack,
  input logic [15:0] out_checksum,
  input logic [63:0] out_payload_low,
  input logic [1:0]  timer_action,
  input logic        message_dropped
);

  a_reset_clears: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid after reset");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(send_valid) && $stable(out_checksum)
      && $stable(timer_action) && $stable(out_payload_low))
    else $error("stalled response changed");

  a_empty_fields: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !send_valid |-> !out_seq && !out_ack && out_checksum == '0
      && out_payload_low == '0)
    else $error("fields not zero without a packet");

  a_send_starts_timer: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && send_valid |-> timer_action == TMR_START && !out_ack && !message_dropped)
    else $error("packet sent without timer start");

  a_drop_alone: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && message_dropped |-> !send_valid && timer_action == TMR_NONE)
    else $error("drop combined with other action");

endmodule

bind alternating_bit_sender_unit abs_checker u_abs_checker (
  .clk             (clk),
  .rst             (rst),
  .rsp_valid       (rsp_valid),
  .rsp_stall       (rsp_stall),
  .send_valid      (send_valid),
  .out_seq         (out_seq),
  .out_ack         (out_ack),
  .out_checksum    (out_checksum),
  .out_payload_low (out_payload_low),
  .timer_action    (timer_action),
  .message_dropped (message_dropped)
);

// ===== tb/sv/alternating_bit_sender_unit_tb.sv =====
module alternating_bit_sender_unit_tb;
  import abs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OP_RESERVED = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_EVENTS = 80;
  localparam int MAX_REPORTS = 40;
  localparam int DRAIN_CYCLES = 10;

  typedef struct {
    logic [63:0] low;
    logic [63:0] mid;
    logic [31:0] high;
  } message_t;

  typedef struct {
    logic        send_valid;
    logic        seq;
    logic        ack;
    logic [15:0] checksum;
    logic [63:0] low;
    logic [63:0] mid;
    logic [31:0] high;
    timer_t      timer;
    logic        dropped;
  } response_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_stall;
  logic [1:0]  opcode = OP_MSG;
  logic [63:0] payload_low = '0;
  logic [63:0] payload_mid = '0;
  logic [31:0] payload_high = '0;
  logic        ack_number = 1'b0;
  logic        seq_number = 1'b0;
  logic [15:0] checksum_in = '0;
  logic        rsp_valid;
  logic        rsp_stall = 1'b0;
  logic        send_valid;
  logic        out_seq;
  logic        out_ack;
  logic [15:0] out_checksum;
  logic [63:0] out_payload_low;
  logic [63:0] out_payload_mid;
  logic [31:0] out_payload_high;
  logic [1:0]  timer_action;
  logic        message_dropped;

  // mirror of the sender state
  logic        seq_bit = 1'b0;
  logic        sender_waiting = 1'b0;
  message_t    held_msg = '{default: '0};
  logic [15:0] held_checksum = '0;
  message_t    message_backlog[$];

  response_t   awaited_responses[$];
  int          mismatches = 0;
  int          cycle_count = 0;
  logic        steady = 1'b0;

  alternating_bit_sender_unit u_top (
    .clk              (clk),
    .rst              (rst),
    .req_valid        (req_valid),
    .req_stall        (req_stall),
    .opcode           (opcode),
    .payload_low      (payload_low),
    .payload_mid      (payload_mid),
    .payload_high     (payload_high),
    .ack_number       (ack_number),
    .seq_number       (seq_number),
    .checksum_in      (checksum_in),
    .rsp_valid        (rsp_valid),
    .rsp_stall        (rsp_stall),
    .send_valid       (send_valid),
    .out_seq          (out_seq),
    .out_ack          (out_ack),
    .out_checksum     (out_checksum),
    .out_payload_low  (out_payload_low),
    .out_payload_mid  (out_payload_mid),
    .out_payload_high (out_payload_high),
    .timer_action     (timer_action),
    .message_dropped  (message_dropped)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(negedge clk) begin
    rsp_stall <= !steady && ($urandom_range(99) < 28);
  end

  function automatic int unsigned byte_total(message_t m);
    int unsigned s;
    s = 0;
    for (int i = 0; i < 8; i++) begin
      s += m.low[8*i +: 8];
      s += m.mid[8*i +: 8];
    end
    for (int i = 0; i < 4; i++) begin
      s += m.high[8*i +: 8];
    end
    return s;
  endfunction

  function automatic logic [15:0] packet_checksum(logic ackb, logic seqb, message_t m);
    int unsigned s;
    s = int'(ackb) + int'(seqb) + byte_total(m);
    return s[15:0];
  endfunction

  function automatic message_t random_message();
    message_t m;
    case ($urandom_range(9))
      0: m = '{default: '0};
      1: m = '{low: '1, mid: '1, high: '1};
      default: begin
        m.low  = {$urandom, $urandom};
        m.mid  = {$urandom, $urandom};
        m.high = $urandom;
      end
    endcase
    return m;
  endfunction

  // applies one request to the mirrored state, returns the response it causes
  function automatic response_t advance_sender(logic [1:0] op, message_t m, logic ackb,
                                               logic seqb, logic [15:0] cks);
    response_t   r;
    logic        emit;
    int unsigned s;
    emit = 1'b0;
    r.send_valid = 1'b0;
    r.seq = 1'b0;
    r.ack = 1'b0;
    r.checksum = '0;
    r.low = '0;
    r.mid = '0;
    r.high = '0;
    r.timer = TMR_NONE;
    r.dropped = 1'b0;
    case (op)
      OP_MSG: begin
        if (!sender_waiting) begin
          held_msg = m;
          s = int'(seq_bit) + byte_total(m);
          held_checksum = s[15:0];
          sender_waiting = 1'b1;
          emit = 1'b1;
        end else if (message_backlog.size() >= QUEUE_DEPTH) begin
          r.dropped = 1'b1;
        end else begin
          message_backlog.push_back(m);
        end
      end
      OP_PACKET: begin
        if (sender_waiting && ackb == seq_bit && packet_checksum(ackb, seqb, m) == cks) begin
          seq_bit = ~seq_bit;
          if (message_backlog.size() > 0) begin
            held_msg = message_backlog.pop_front();
            s = int'(seq_bit) + byte_total(held_msg);
            held_checksum = s[15:0];
            emit = 1'b1;
          end else begin
            sender_waiting = 1'b0;
            r.timer = TMR_STOP;
          end
        end
      end
      OP_TIMEOUT: begin
        if (sender_waiting) emit = 1'b1;
      end
      default: ;
    endcase
    if (emit) begin
      r.send_valid = 1'b1;
      r.seq = seq_bit;
      r.checksum = held_checksum;
      r.low = held_msg.low;
      r.mid = held_msg.mid;
      r.high = held_msg.high;
      r.timer = TMR_START;
    end
    return r;
  endfunction

  task automatic flag_mismatch(string field, logic [63:0] got, logic [63:0] want);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("%0t ns: %s got %0h, want %0h", $time, field, got, want);
    end
  endtask

  always @(posedge clk) begin
    response_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (awaited_responses.size() == 0) begin
        flag_mismatch("response with no request pending", 1, 0);
      end else begin
        want = awaited_responses.pop_front();
        if (send_valid !== want.send_valid)
          flag_mismatch("send_valid", send_valid, want.send_valid);
        if (out_seq !== want.seq) flag_mismatch("out_seq", out_seq, want.seq);
        if (out_ack !== want.ack) flag_mismatch("out_ack", out_ack, want.ack);
        if (out_checksum !== want.checksum)
          flag_mismatch("out_checksum", out_checksum, want.checksum);
        if (out_payload_low !== want.low)
          flag_mismatch("out_payload_low", out_payload_low, want.low);
        if (out_payload_mid !== want.mid)
          flag_mismatch("out_payload_mid", out_payload_mid, want.mid);
        if (out_payload_high !== want.high)
          flag_mismatch("out_payload_high", out_payload_high, want.high);
        if (timer_action !== want.timer)
          flag_mismatch("timer_action", timer_action, want.timer);
        if (message_dropped !== want.dropped)
          flag_mismatch("message_dropped", message_dropped, want.dropped);
      end
    end
  end

  // called and returns at a falling edge; valid stays high for a back-to-back request
  task automatic send_event(logic [1:0] op, message_t m, logic ackb, logic seqb,
                            logic [15:0] cks);
    if (!steady) begin
      while ($urandom_range(99) < 28) begin
        req_valid <= 1'b0;
        @(negedge clk);
      end
    end
    opcode       <= op;
    payload_low  <= m.low;
    payload_mid  <= m.mid;
    payload_high <= m.high;
    ack_number   <= ackb;
    seq_number   <= seqb;
    checksum_in  <= cks;
    req_valid    <= 1'b1;
    do @(posedge clk); while (req_stall);
    awaited_responses.push_back(advance_sender(op, m, ackb, seqb, cks));
    @(negedge clk);
  endtask

  task automatic send_bare(logic [1:0] op, message_t m);
    send_event(op, m, 1'($urandom), 1'($urandom), 16'($urandom));
  endtask

  task automatic send_good_ack(message_t m, logic seqb);
    send_event(OP_PACKET, m, seq_bit, seqb, packet_checksum(seq_bit, seqb, m));
  endtask

  task automatic settle_responses();
    req_valid <= 1'b0;
    do @(negedge clk); while (awaited_responses.size() != 0);
  endtask

  task automatic test_idle_events();
    message_t m;
    m = random_message();
    send_good_ack(m, 1'b1);
    send_bare(OP_TIMEOUT, random_message());
    send_bare(OP_RESERVED, random_message());
  endtask

  task automatic test_basic_exchange();
    message_t zeros;
    message_t ones;
    message_t m;
    zeros = '{default: '0};
    ones = '{low: '1, mid: '1, high: '1};
    send_event(OP_MSG, zeros, 1'b0, 1'b0, 16'h0000);
    m = random_message();
    // wrong ack bit with a good checksum, then right bit with a bad checksum
    send_event(OP_PACKET, m, ~seq_bit, 1'b0, packet_checksum(~seq_bit, 1'b0, m));
    send_event(OP_PACKET, ones, seq_bit, 1'b1, 16'hFFFF);
    send_bare(OP_TIMEOUT, random_message());
    send_bare(OP_RESERVED, ones);
    send_event(OP_MSG, ones, 1'b1, 1'b1, 16'hFFFF);
    send_bare(OP_MSG, random_message());
    send_good_ack(zeros, 1'b0);
    send_good_ack(ones, 1'b1);
    send_bare(OP_TIMEOUT, ones);
    send_good_ack(random_message(), 1'b0);
    send_bare(OP_MSG, random_message());
    send_bare(OP_TIMEOUT, zeros);
    send_good_ack(ones, 1'b1);
    send_bare(OP_TIMEOUT, random_message());
  endtask

  task automatic test_queue_overflow();
    steady = 1'b1;
    while (message_backlog.size() < QUEUE_DEPTH) send_bare(OP_MSG, random_message());
    steady = 1'b0;
    repeat (3) send_bare(OP_MSG, random_message());
    settle_responses();
    send_bare(OP_TIMEOUT, random_message());
    repeat (8) send_good_ack(random_message(), 1'($urandom));
  endtask

  task automatic test_random_traffic();
    int          acted;
    int unsigned pick;
    message_t    m;
    logic        seqb;
    acted = 0;
    while (acted < RANDOM_EVENTS) begin
      pick = $urandom_range(99);
      m = random_message();
      seqb = 1'($urandom);
      if (sender_waiting) begin
        if (pick < 35) begin
          send_good_ack(m, seqb);
          acted++;
        end else if (pick < 62) begin
          send_bare(OP_MSG, m);
          acted++;
        end else if (pick < 72) begin
          send_bare(OP_TIMEOUT, m);
          acted++;
        end else if (pick < 80) begin
          send_event(OP_PACKET, m, ~seq_bit, seqb, packet_checksum(~seq_bit, seqb, m));
        end else if (pick < 90) begin
          send_event(OP_PACKET, m, seq_bit, seqb, 16'($urandom));
        end else begin
          send_bare(OP_RESERVED, m);
        end
      end else begin
        if (pick < 75) begin
          send_bare(OP_MSG, m);
          acted++;
        end else if (pick < 85) begin
          send_good_ack(m, seqb);
        end else if (pick < 95) begin
          send_bare(OP_TIMEOUT, m);
        end else begin
          send_bare(OP_RESERVED, m);
        end
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_idle_events();
    test_basic_exchange();
    test_queue_overflow();
    test_random_traffic();
    req_valid <= 1'b0;
    while (awaited_responses.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/abs_pkg.sv
design/alternating_bit_sender_unit.sv
design/abs_checker.sv
tb/sv/alternating_bit_sender_unit_tb.sv
